// File: src/text_encoding_sniffer_defines.svh
// Assertion helpers used by the checker file tes_checker.sv.
`ifndef TEXT_ENCODING_SNIFFER_DEFINES_SVH
`define TEXT_ENCODING_SNIFFER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define TES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define TES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TES_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tes_pkg.sv
package tes_pkg;

    localparam int LIMIT_W = 13;
    localparam int POS_OUT_W = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4000;

    typedef enum logic [2:0] {
        V_UTF8        = 3'd0,
        V_UTF8_BOM    = 3'd1,
        V_UTF16LE_BOM = 3'd2,
        V_UTF16BE_BOM = 3'd3,
        V_UTF16LE     = 3'd4,
        V_UTF16BE     = 3'd5,
        V_CP850       = 3'd6,
        V_CP1252      = 3'd7
    } t_verdict;

    // BOM bytes
    localparam logic [7:0] BOM_EF = 8'hEF;
    localparam logic [7:0] BOM_BB = 8'hBB;
    localparam logic [7:0] BOM_BF = 8'hBF;
    localparam logic [7:0] BOM_FF = 8'hFF;
    localparam logic [7:0] BOM_FE = 8'hFE;

    // UTF-8 class boundaries (lower bounds, inclusive)
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] BAD_LEAD   = 8'hA0;
    localparam logic [7:0] CONT_END   = 8'hC0;
    localparam logic [7:0] LEAD_2B    = 8'hC2;
    localparam logic [7:0] LEAD_3B    = 8'hE0;
    localparam logic [7:0] LEAD_4B    = 8'hF0;
    localparam logic [7:0] LEAD_OVER  = 8'hF5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            verdict;
        logic [POS_OUT_W-1:0]  decided_at;
    } t_out_item;

    // Input register contents handed to the scan stage.
    typedef struct packed {
        logic     vld;
        t_in_item item;
    } t_stage;

endpackage

// File: src/tes_in_reg.sv
module tes_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tes_pkg::t_in_item i_item,
    input  logic              i_advance,
    output tes_pkg::t_stage   o_stage
);
    import tes_pkg::*;

    logic     r_vld;
    t_in_item r_item;

    assign o_ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_stage.vld  = r_vld;
    assign o_stage.item = r_item;

endmodule

// File: src/tes_scan.sv
module tes_scan #(
    parameter int WINDOW_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tes_pkg::t_stage               i_stage,
    input  logic [tes_pkg::LIMIT_W-1:0]   i_limit,
    input  logic                          i_out_free,
    output logic                          o_advance,
    output logic                          o_res_vld,
    output tes_pkg::t_out_item            o_res
);
    import tes_pkg::*;

    localparam int PW = $clog2(WINDOW_BYTES + 1);
    localparam int CW = (PW > LIMIT_W) ? PW : LIMIT_W;
    localparam logic [PW-1:0] WIN_END = PW'(WINDOW_BYTES);

    logic [PW-1:0]        r_pos, n_pos;
    logic [1:0]           r_pend, n_pend;
    logic [7:0]           r_first, n_first;
    logic [7:0]           r_second, n_second;
    t_verdict             r_held, n_held;
    logic                 r_decided, n_decided;
    logic [POS_OUT_W-1:0] r_dpos, n_dpos;

    logic [7:0] b;
    logic       in_win;
    logic       below_limit;
    logic       is_cont;

    assign b           = i_stage.item.data_byte;
    assign in_win      = r_pos < WIN_END;
    assign below_limit = CW'(r_pos) < CW'(i_limit);
    assign is_cont     = (b >= CONT_LO) && (b < CONT_END);
    assign o_advance   = i_stage.vld && (!i_stage.item.last || i_out_free);
    assign o_res_vld   = o_advance && i_stage.item.last;

    always_comb begin
        n_pos     = r_pos;
        n_pend    = r_pend;
        n_first   = r_first;
        n_second  = r_second;
        n_held    = r_held;
        n_decided = r_decided;
        n_dpos    = r_dpos;

        if (in_win) begin
            if (r_pos == PW'(0)) begin
                n_first = b;
            end
            if (r_pos == PW'(1)) begin
                n_second = b;
            end

            if (!r_decided) begin
                if (r_pend != 2'd0) begin
                    if (is_cont) begin
                        n_pend = r_pend - 2'd1;
                    end else begin
                        n_held    = V_CP1252;
                        n_decided = 1'b1;
                        n_dpos    = POS_OUT_W'(r_pos);
                    end
                end else if (below_limit) begin
                    if (b == 8'h00) begin
                        n_held    = r_pos[0] ? V_UTF16BE : V_UTF16LE;
                        n_decided = 1'b1;
                        n_dpos    = POS_OUT_W'(r_pos);
                    end else if (b < CONT_LO) begin
                        n_pend = 2'd0;
                    end else if (b < BAD_LEAD) begin
                        n_held    = V_CP850;
                        n_decided = 1'b1;
                        n_dpos    = POS_OUT_W'(r_pos);
                    end else if (b < LEAD_2B) begin
                        n_held    = V_CP1252;
                        n_decided = 1'b1;
                        n_dpos    = POS_OUT_W'(r_pos);
                    end else if (b < LEAD_3B) begin
                        n_pend = 2'd1;
                    end else if (b < LEAD_4B) begin
                        n_pend = 2'd2;
                    end else if (b < LEAD_OVER) begin
                        n_pend = 2'd3;
                    end else begin
                        n_held    = V_CP1252;
                        n_decided = 1'b1;
                        n_dpos    = POS_OUT_W'(r_pos);
                    end
                end
            end

            // a BOM wins over whatever the scan decided on its bytes
            if (r_pos == PW'(1) && r_first == BOM_FF && b == BOM_FE) begin
                n_held    = V_UTF16LE_BOM;
                n_decided = 1'b1;
                n_dpos    = POS_OUT_W'(r_pos);
            end else if (r_pos == PW'(1) && r_first == BOM_FE && b == BOM_FF) begin
                n_held    = V_UTF16BE_BOM;
                n_decided = 1'b1;
                n_dpos    = POS_OUT_W'(r_pos);
            end else if (r_pos == PW'(2) && r_first == BOM_EF && r_second == BOM_BB
                         && b == BOM_BF) begin
                n_held    = V_UTF8_BOM;
                n_decided = 1'b1;
                n_dpos    = POS_OUT_W'(r_pos);
            end

            n_pos = r_pos + PW'(1);
        end
    end

    assign o_res.verdict    = n_decided ? n_held : V_UTF8;
    assign o_res.decided_at = n_decided ? n_dpos : POS_OUT_W'(n_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pend    <= 2'd0;
            r_first   <= 8'h00;
            r_second  <= 8'h00;
            r_held    <= V_UTF8;
            r_decided <= 1'b0;
            r_dpos    <= '0;
        end else if (o_advance) begin
            if (i_stage.item.last) begin
                // end of file: start over for the next one
                r_pos     <= '0;
                r_pend    <= 2'd0;
                r_first   <= 8'h00;
                r_second  <= 8'h00;
                r_held    <= V_UTF8;
                r_decided <= 1'b0;
                r_dpos    <= '0;
            end else begin
                r_pos     <= n_pos;
                r_pend    <= n_pend;
                r_first   <= n_first;
                r_second  <= n_second;
                r_held    <= n_held;
                r_decided <= n_decided;
                r_dpos    <= n_dpos;
            end
        end
    end

endmodule

// File: src/tes_out_reg.sv
module tes_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tes_pkg::t_out_item i_res,
    output logic               o_free,
    output logic               o_valid,
    input  logic               i_ready,
    output tes_pkg::t_out_item o_item
);
    import tes_pkg::*;

    logic      r_vld;
    t_out_item r_item;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_res;
        end
    end

endmodule

// File: src/text_encoding_sniffer.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_in  (data_byte, last)
// out       output     o_out_valid / i_out_ready   o_out (verdict, decided_at)
// cfg       input      i_cfg_wr_en                 i_cfg_wr_data (lead_scan_limit)
//
// One byte per cycle unless the input stalls; a verdict is loaded into the result register from its last byte.
// Bytes go input register -> scan logic -> result register, one short stage each.
// The input stalls only while a last byte waits on a full result register.
// Synchronous active-low reset clears the file state and sets the limit to 4000.
module text_encoding_sniffer #(
    parameter int WINDOW_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tes_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tes_pkg::t_out_item            o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [tes_pkg::LIMIT_W-1:0]   i_cfg_wr_data
);
    import tes_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    t_stage             stage;
    logic               advance;
    logic               res_vld;
    t_out_item          res;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    tes_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in),
        .i_advance (advance),
        .o_stage   (stage)
    );

    tes_scan #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stage    (stage),
        .i_limit    (r_limit),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    tes_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_vld),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out)
    );

endmodule

// File: src/tes_checker.sv
`include "text_encoding_sniffer_defines.svh"

module tes_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input tes_pkg::t_out_item o_out
);
    import tes_pkg::*;

    `TES_ASSERT_ALWAYS_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

    `TES_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "stalled result changed")

    `TES_ASSERT_NOW(a_bom_position, i_clk, i_rst_n, o_out_valid && (o_out.verdict == V_UTF16LE_BOM || o_out.verdict == V_UTF16BE_BOM || o_out.verdict == V_UTF8_BOM), (o_out.verdict == V_UTF8_BOM) ? (o_out.decided_at == 13'd2) : (o_out.decided_at == 13'd1), "BOM verdict at wrong position")

    `TES_ASSERT_NOW(a_utf16_parity, i_clk, i_rst_n, o_out_valid && (o_out.verdict == V_UTF16LE || o_out.verdict == V_UTF16BE), o_out.decided_at[0] == (o_out.verdict == V_UTF16BE), "UTF-16 verdict disagrees with zero byte parity")

endmodule

bind text_encoding_sniffer tes_checker u_tes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
